[design/nnsc_pkg.sv]
// Package: shared types, codes and constants of the nearest-neighbor scaler.
`timescale 1ns / 1ps
package nnsc_pkg;

  // Item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_SRC_W = 3'd0;
  localparam logic [2:0] REG_SRC_H = 3'd1;
  localparam logic [2:0] REG_TGT_W = 3'd2;
  localparam logic [2:0] REG_TGT_H = 3'd3;
  localparam logic [2:0] REG_VPC   = 3'd4;

  localparam int          DIM_W      = 11;
  localparam int          VPC_W      = 17;
  localparam int          CFG_IDX_W  = 3;
  localparam int          CFG_DATA_W = 17;
  localparam int          FRAME_PIXELS_DEF = 65536;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

  typedef struct packed {
    logic        mode;
    logic [15:0] pixel_index;
    logic [7:0]  blue_in;
    logic [7:0]  green_in;
    logic [7:0]  red_in;
    logic [9:0]  out_col;
    logic [9:0]  out_row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       from_source;
    logic       frame_error;
  } out_item_t;

endpackage

[design/nnsc_stream_if.sv]
// Interface: valid/ready stream channel carrying one payload item.
`timescale 1ns / 1ps
interface nnsc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/nnsc_frame_store.sv]
// Frame store: one write port and one registered read port.
`timescale 1ns / 1ps
module nnsc_frame_store #(
  parameter int DEPTH = 65536,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [23:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [23:0]   rdata_o
);
  logic [23:0] mem [DEPTH];

  // Write a loaded pixel
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read, hold on stall
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

[design/nearest_neighbor_bgra_to_rgba_scaler_unit.sv]
// Top level: pipelined nearest-neighbor scaler from a BGR frame store to RGBA pixels.
//
// Usage: items arrive on in_ch (valid/ready). A load item (mode 0) writes blue,
// green and red at pixel_index; it gives no result. A fetch item (mode 1) names an
// output column and row; one RGBA result leaves on out_ch per fetch.
// Sizes and the valid pixel count are set through the write port (cfg_we_i,
// cfg_idx_i, cfg_data_i) while the block is idle.
// Throughput: one item per cycle while out_ch.ready is high. Depth: the pipeline
// is set by the 11-stage one-bit-per-stage quotient pipeline of each axis, plus
// the input multiply, clamp, index multiply, frame store read and output register.
// A load writes the store when it reaches the read stage, so a later fetch always
// sees it.
// Reset: all sizes become 1, the valid count 0, the pipeline empties. The store
// itself is not cleared; fetch only pixels that were loaded.
// Stall: when out_ch.ready is low, the result holds and stages behind it fill;
// in_ch.ready drops only once every stage holds an item. Nothing is lost.
`timescale 1ns / 1ps
module nearest_neighbor_bgra_to_rgba_scaler_unit #(
  parameter int FRAME_PIXELS = nnsc_pkg::FRAME_PIXELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nnsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nnsc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  nnsc_stream_if.sink                   in_ch,
  nnsc_stream_if.source                 out_ch
);
  import nnsc_pkg::*;

  localparam int AW       = $clog2(FRAME_PIXELS);
  localparam int NS       = 16;
  localparam int ST_CLAMP = 12;
  localparam int ST_INDEX = 13;
  localparam int ST_MEM   = 14;
  localparam int ST_OUT   = 15;

  typedef struct packed {
    logic        mode;
    logic [15:0] idx;
    logic [23:0] rgb;
    logic [20:0] rx;
    logic [20:0] ry;
    logic [10:0] qx;
    logic [10:0] qy;
    logic        ovx;
    logic        ovy;
    logic [21:0] pix;
    logic        hit;
  } stage_t;

  // Configuration registers
  logic [DIM_W-1:0] src_w_q, src_h_q, tgt_w_q, tgt_h_q;
  logic [VPC_W-1:0] vpc_q;
  logic [21:0]      area_q, usable_q;
  logic [DIM_W-1:0] sw_eff, sh_eff, tw_eff, th_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= DIM_W'(1);
      src_h_q <= DIM_W'(1);
      tgt_w_q <= DIM_W'(1);
      tgt_h_q <= DIM_W'(1);
      vpc_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SRC_W: src_w_q <= cfg_data_i[DIM_W-1:0];
        REG_SRC_H: src_h_q <= cfg_data_i[DIM_W-1:0];
        REG_TGT_W: tgt_w_q <= cfg_data_i[DIM_W-1:0];
        REG_TGT_H: tgt_h_q <= cfg_data_i[DIM_W-1:0];
        REG_VPC:   vpc_q   <= cfg_data_i[VPC_W-1:0];
        default: ;
      endcase
    end
  end

  // Treat zero sizes as one
  assign sw_eff = (src_w_q == '0) ? DIM_W'(1) : src_w_q;
  assign sh_eff = (src_h_q == '0) ? DIM_W'(1) : src_h_q;
  assign tw_eff = (tgt_w_q == '0) ? DIM_W'(1) : tgt_w_q;
  assign th_eff = (tgt_h_q == '0) ? DIM_W'(1) : tgt_h_q;

  // Usable pixel count from frame area and valid count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q   <= 22'd1;
      usable_q <= '0;
    end else begin
      area_q   <= 22'(sw_eff) * 22'(sh_eff);
      usable_q <= (22'(vpc_q) < area_q) ? 22'(vpc_q) : area_q;
    end
  end

  // Pipeline registers and advance chain
  stage_t      st_q [NS];
  stage_t      st_d [NS];
  logic [NS-1:0] v_q;
  logic [NS:0]   adv;
  logic [23:0]   rdata;
  out_item_t     out_q, out_d;

  always_comb begin
    adv[NS] = out_ch.ready || (st_q[ST_OUT].mode == MODE_LOAD);
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_ch.ready = adv[0];

  // Stage 0: capture item, scale coordinates by source size
  always_comb begin
    st_d[0]      = '0;
    st_d[0].mode = in_ch.data.mode;
    st_d[0].idx  = in_ch.data.pixel_index;
    st_d[0].rgb  = {in_ch.data.red_in, in_ch.data.green_in, in_ch.data.blue_in};
    st_d[0].rx   = 21'(in_ch.data.out_col) * 21'(sw_eff);
    st_d[0].ry   = 21'(in_ch.data.out_row) * 21'(sh_eff);
  end

  // Stages 1..11: one quotient bit per axis each
  for (genvar j = 1; j <= 11; j++) begin : g_div
    localparam int B = 11 - j;
    always_comb begin
      logic        ovx_n;
      logic        ovy_n;
      logic [21:0] tx;
      logic [21:0] ty;
      st_d[j] = st_q[j-1];
      ovx_n   = st_q[j-1].ovx;
      ovy_n   = st_q[j-1].ovy;
      if (j == 1) begin
        ovx_n = {1'b0, st_q[j-1].rx} >= (22'(tw_eff) << 11);
        ovy_n = {1'b0, st_q[j-1].ry} >= (22'(th_eff) << 11);
      end
      st_d[j].ovx = ovx_n;
      st_d[j].ovy = ovy_n;
      tx = 22'(tw_eff) << B;
      ty = 22'(th_eff) << B;
      if (!ovx_n && ({1'b0, st_q[j-1].rx} >= tx)) begin
        st_d[j].rx    = 21'({1'b0, st_q[j-1].rx} - tx);
        st_d[j].qx[B] = 1'b1;
      end
      if (!ovy_n && ({1'b0, st_q[j-1].ry} >= ty)) begin
        st_d[j].ry    = 21'({1'b0, st_q[j-1].ry} - ty);
        st_d[j].qy[B] = 1'b1;
      end
    end
  end

  // Clamp to the source edge
  always_comb begin
    st_d[ST_CLAMP] = st_q[ST_CLAMP-1];
    if (st_q[ST_CLAMP-1].ovx || (st_q[ST_CLAMP-1].qx >= sw_eff - DIM_W'(1))) begin
      st_d[ST_CLAMP].qx = sw_eff - DIM_W'(1);
    end
    if (st_q[ST_CLAMP-1].ovy || (st_q[ST_CLAMP-1].qy >= sh_eff - DIM_W'(1))) begin
      st_d[ST_CLAMP].qy = sh_eff - DIM_W'(1);
    end
  end

  // Form source index and range check
  always_comb begin
    st_d[ST_INDEX]     = st_q[ST_INDEX-1];
    st_d[ST_INDEX].pix = 22'(st_q[ST_INDEX-1].qy) * 22'(sw_eff)
                       + 22'(st_q[ST_INDEX-1].qx);
  end

  always_comb begin
    st_d[ST_MEM]     = st_q[ST_MEM-1];
    st_d[ST_MEM].hit = (32'(st_q[ST_MEM-1].pix) < 32'(FRAME_PIXELS))
                    && (st_q[ST_MEM-1].pix < usable_q);
  end

  assign st_d[ST_OUT] = st_q[ST_OUT-1];

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= (k == 0) ? in_ch.valid : v_q[k-1];
        end
      end
    end
  end

  // Stage payload, advance when the slot frees
  for (genvar k = 0; k < NS; k++) begin : g_st
    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // Frame store access: loads write, fetches read, in item order
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;

  assign mem_we    = adv[ST_MEM] && v_q[ST_MEM-1] && (st_q[ST_MEM-1].mode == MODE_LOAD)
                  && (32'(st_q[ST_MEM-1].idx) < 32'(FRAME_PIXELS));
  assign mem_waddr = AW'(st_q[ST_MEM-1].idx);
  assign mem_raddr = AW'(st_q[ST_MEM-1].pix);

  nnsc_frame_store #(
    .DEPTH (FRAME_PIXELS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (st_q[ST_MEM-1].rgb),
    .re_i    (adv[ST_MEM]),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  // Build result; black fill on miss or empty frame
  always_comb begin
    out_d             = '0;
    out_d.alpha_out   = ALPHA_OPAQUE;
    out_d.frame_error = (vpc_q == '0);
    if ((vpc_q != '0) && st_q[ST_MEM].hit) begin
      out_d.red_out     = rdata[23:16];
      out_d.green_out   = rdata[15:8];
      out_d.blue_out    = rdata[7:0];
      out_d.from_source = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_OUT]) begin
      out_q <= out_d;
    end
  end

  assign out_ch.valid = v_q[ST_OUT] && (st_q[ST_OUT].mode == MODE_FETCH);
  assign out_ch.data  = out_q;

`ifndef SYNTHESIS
  a_err_no_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.data.frame_error |-> !out_ch.data.from_source)
    else $error("frame error result marked as source pixel");

  a_fill_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.data.from_source |->
      (out_ch.data.red_out == 8'd0) && (out_ch.data.green_out == 8'd0)
      && (out_ch.data.blue_out == 8'd0))
    else $error("black fill carries color");

  a_entry_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && !adv[0] |=> v_q[0])
    else $error("stalled entry stage lost its item");
`endif
endmodule
